// File: sv/rwl_pkg.sv
package rwl_pkg;

	// Waiting room per queue and significant bits of a thread identifier.
	localparam int QUEUE_DEPTH = 16;
	localparam int TID_BITS = 8;

	// Widths of the stream fields.
	localparam int TID_FIELD_W = 8;
	localparam int KIND_W = 2;
	localparam int CODE_W = 3;

	// Identifier bits that survive the 8-bit field.
	localparam int TID_W = (TID_BITS < TID_FIELD_W) ? TID_BITS : TID_FIELD_W;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	localparam int RC_W = 9;
	localparam logic [RC_W-1:0] RC_MAX = '1;

	typedef logic [TID_W-1:0] tid_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [RC_W-1:0] rc_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_UNLOCK = 2'd2
	} kind_t;

	typedef enum logic [CODE_W-1:0] {
		RES_GRANTED = 3'd0,
		RES_QUEUED = 3'd1,
		RES_NOT_OWNER = 3'd2,
		RES_FULL = 3'd3,
		RES_WAKE_READ = 3'd4,
		RES_WAKE_WRITE = 3'd5
	} res_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAKE_W,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		res_code_t code;
		tid_t tid;
		logic last;
	} res_t;

	typedef struct packed {
		logic we;
		ptr_t waddr;
		tid_t wdata;
		logic re;
		ptr_t raddr;
	} ram_req_t;

	// Tail slot of a ring buffer: head plus fill, wrapped once.
	function automatic ptr_t ring_addr(input ptr_t head, input cnt_t cnt);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(head) + SUM_W'(cnt);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			sum = sum - SUM_W'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	function automatic ptr_t ring_inc(input ptr_t head);
		return (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
	endfunction

endpackage

// File: sv/writer_preferring_rwlock.sv
// Reader-writer lock manager that favors writers.
// Requests arrive as beats on the s_axis channel: tuser carries the kind (read lock,
// write lock, unlock) and tdata the requesting thread. Results leave as beats on the
// m_axis channel: tuser carries the result code, tdata the thread concerned, and tlast
// marks the final result that a request causes. A request kind of 3 is dropped silently.
// The block works on one request at a time. An accepted beat is registered, and its
// first result then goes to the output register; only after that can the next request
// be taken. An unlock that hands the lock to a waiting writer passes through a further
// state, since the writer's identifier comes out of the registered read port of the
// writer queue memory. An unlock that wakes queued readers drains them one by one: the
// reader queue memory is read once per cycle while the receiver does not stall, one
// reader per result beat.
// Both wait queues are ring buffers in single-port-per-direction memories; pushes and
// pops never touch the same entry in one cycle because requests are serialized.
// Reset clears the lock, the reader count and both queue fills at once; the queue
// memories need no clearing. When the receiver stalls, the output register holds its
// beat and the sequencer waits, so no result is lost and no new request is accepted
// until all results of the current one have entered the output register.
module writer_preferring_rwlock import rwl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TID_FIELD_W-1:0] s_axis_tdata,  // [7:0] requester_tid
	input  logic [KIND_W-1:0]      s_axis_tuser,  // [1:0] kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TID_FIELD_W-1:0] m_axis_tdata,  // [7:0] thread_id
	output logic [CODE_W-1:0]      m_axis_tuser,  // [2:0] result_code
	output logic                   m_axis_tlast
);

	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_res;
	ram_req_t wq_req;
	ram_req_t rq_req;
	tid_t wq_rdata;
	tid_t rq_rdata;

	// Sequencer holding the lock state and the queue pointers.
	rwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_tid   (s_axis_tdata[TID_W-1:0]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.wq_req   (wq_req),
		.wq_rdata (wq_rdata),
		.rq_req   (rq_req),
		.rq_rdata (rq_rdata)
	);

	// Waiting writers.
	rwl_ram #(.WIDTH(TID_W), .DEPTH(QUEUE_DEPTH)) u_wq_ram (
		.clk  (clk),
		.we   (wq_req.we),
		.waddr(wq_req.waddr),
		.wdata(wq_req.wdata),
		.re   (wq_req.re),
		.raddr(wq_req.raddr),
		.rdata(wq_rdata)
	);

	// Waiting readers.
	rwl_ram #(.WIDTH(TID_W), .DEPTH(QUEUE_DEPTH)) u_rq_ram (
		.clk  (clk),
		.we   (rq_req.we),
		.waddr(rq_req.waddr),
		.wdata(rq_req.wdata),
		.re   (rq_req.re),
		.raddr(rq_req.raddr),
		.rdata(rq_rdata)
	);

	// Output register between the sequencer and the result channel.
	rwl_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_res   (res),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = TID_FIELD_W'(out_res.tid);
	assign m_axis_tuser = out_res.code;
	assign m_axis_tlast = out_res.last;

endmodule

// File: sv/rwl_ram.sv
module rwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/rwl_out.sv
module rwl_out import rwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_res,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;

	// The register can take a new beat when empty or when its beat leaves now.
	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule

// File: sv/rwl_ctrl.sv
module rwl_ctrl import rwl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [KIND_W-1:0] in_kind,
	input  tid_t     in_tid,
	output logic     res_valid,
	input  logic     res_ready,
	output res_t     res,
	output ram_req_t wq_req,
	input  tid_t     wq_rdata,
	output ram_req_t rq_req,
	input  tid_t     rq_rdata
);

	state_t state_q, state_d;
	logic [KIND_W-1:0] kind_q;
	tid_t tid_q;

	logic wh_q, wh_d;
	tid_t owner_q, owner_d;
	rc_t rc_q, rc_d;
	cnt_t wq_cnt_q, wq_cnt_d, rq_cnt_q, rq_cnt_d;
	ptr_t wq_head_q, wq_head_d, rq_head_q, rq_head_d;

	logic rel_ok;
	rc_t rc_rel;
	logic wake_w;
	logic wake_r;

	// Unlock decode: a valid release, and what follows once the lock is free.
	always_comb begin
		rel_ok = (kind_q == KIND_UNLOCK) && (wh_q ? (owner_q == tid_q) : (rc_q != '0));
		rc_rel = wh_q ? rc_q : rc_q - RC_W'(1);
		wake_w = rel_ok && (rc_rel == '0) && (wq_cnt_q != '0);
		wake_r = rel_ok && (rc_rel == '0) && (wq_cnt_q == '0) && (rq_cnt_q != '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (kind_q != KIND_READ && kind_q != KIND_WRITE && kind_q != KIND_UNLOCK) begin
					state_d = ST_IDLE;
				end else if (res_ready) begin
					if (wake_w) begin
						state_d = ST_WAKE_W;
					end else if (wake_r) begin
						state_d = ST_DRAIN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_WAKE_W: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (res_ready && rq_cnt_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		res_valid = 1'b0;
		res.code = RES_GRANTED;
		res.tid = tid_q;
		res.last = 1'b1;
		wq_req = '0;
		rq_req = '0;
		wh_d = wh_q;
		owner_d = owner_q;
		rc_d = rc_q;
		wq_cnt_d = wq_cnt_q;
		wq_head_d = wq_head_q;
		rq_cnt_d = rq_cnt_q;
		rq_head_d = rq_head_q;

		unique case (state_q)
			ST_EXEC: begin
				if (res_ready) begin
					unique case (kind_q)
						KIND_READ: begin
							res_valid = 1'b1;
							if (!wh_q && wq_cnt_q == '0) begin
								if (rc_q == RC_MAX) begin
									res.code = RES_FULL;
								end else begin
									rc_d = rc_q + RC_W'(1);
								end
							end else if (rq_cnt_q == CNT_W'(QUEUE_DEPTH)) begin
								res.code = RES_FULL;
							end else begin
								res.code = RES_QUEUED;
								rq_req.we = 1'b1;
								rq_req.waddr = ring_addr(rq_head_q, rq_cnt_q);
								rq_req.wdata = tid_q;
								rq_cnt_d = rq_cnt_q + CNT_W'(1);
							end
						end
						KIND_WRITE: begin
							res_valid = 1'b1;
							if (!wh_q && rc_q == '0) begin
								wh_d = 1'b1;
								owner_d = tid_q;
							end else if (wq_cnt_q == CNT_W'(QUEUE_DEPTH)) begin
								res.code = RES_FULL;
							end else begin
								res.code = RES_QUEUED;
								wq_req.we = 1'b1;
								wq_req.waddr = ring_addr(wq_head_q, wq_cnt_q);
								wq_req.wdata = tid_q;
								wq_cnt_d = wq_cnt_q + CNT_W'(1);
							end
						end
						KIND_UNLOCK: begin
							res_valid = 1'b1;
							if (!rel_ok) begin
								res.code = RES_NOT_OWNER;
							end else begin
								res.last = !(wake_w || wake_r);
								wh_d = 1'b0;
								owner_d = '0;
								rc_d = rc_rel;
								if (wake_w) begin
									// Ownership moves now; the identifier lands in the next cycle.
									wq_req.re = 1'b1;
									wq_req.raddr = wq_head_q;
									wq_head_d = ring_inc(wq_head_q);
									wq_cnt_d = wq_cnt_q - CNT_W'(1);
									wh_d = 1'b1;
								end
								if (wake_r) begin
									rq_req.re = 1'b1;
									rq_req.raddr = rq_head_q;
									rq_head_d = ring_inc(rq_head_q);
									rq_cnt_d = rq_cnt_q - CNT_W'(1);
									rc_d = RC_W'(1);
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_WAKE_W: begin
				if (res_ready) begin
					res_valid = 1'b1;
					res.code = RES_WAKE_WRITE;
					res.tid = wq_rdata;
					owner_d = wq_rdata;
				end
			end
			ST_DRAIN: begin
				// Read data holds while the output stalls, since no new read is issued.
				if (res_ready) begin
					res_valid = 1'b1;
					res.code = RES_WAKE_READ;
					res.tid = rq_rdata;
					res.last = (rq_cnt_q == '0);
					if (rq_cnt_q != '0) begin
						rq_req.re = 1'b1;
						rq_req.raddr = rq_head_q;
						rq_head_d = ring_inc(rq_head_q);
						rq_cnt_d = rq_cnt_q - CNT_W'(1);
						rc_d = rc_q + RC_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wh_q <= 1'b0;
			owner_q <= '0;
			rc_q <= '0;
			wq_cnt_q <= '0;
			wq_head_q <= '0;
			rq_cnt_q <= '0;
			rq_head_q <= '0;
		end else begin
			state_q <= state_d;
			wh_q <= wh_d;
			owner_q <= owner_d;
			rc_q <= rc_d;
			wq_cnt_q <= wq_cnt_d;
			wq_head_q <= wq_head_d;
			rq_cnt_q <= rq_cnt_d;
			rq_head_q <= rq_head_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_q <= in_kind;
			tid_q <= in_tid;
		end
	end

endmodule

// File: sv/rwl_checker.sv
module rwl_checker import rwl_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [TID_FIELD_W-1:0] s_axis_tdata,
	input logic [KIND_W-1:0]      s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [TID_FIELD_W-1:0] m_axis_tdata,
	input logic [CODE_W-1:0]      m_axis_tuser,
	input logic                   m_axis_tlast
);

	// One request at a time: the input closes right after a beat is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while the previous one is in work");

	// While a request still has results to deliver, no new request is taken.
	a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input open while a result burst is pending");

	// Only an unlock grant or a woken reader can be followed by more results.
	a_nonlast_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |->
			(m_axis_tuser == RES_GRANTED) || (m_axis_tuser == RES_WAKE_READ))
		else $error("result code that must end a burst came without tlast");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result beat changed");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= RES_WAKE_WRITE)
		else $error("result code out of range");

endmodule

bind writer_preferring_rwlock rwl_checker u_rwl_checker (.*);

// File: dv/rwlock_result_checker.sv
`timescale 1ns / 100ps

module rwlock_result_checker import rwl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_ready,
	input  logic [TID_FIELD_W-1:0] req_tid,
	input  logic [KIND_W-1:0]      req_kind,
	input  logic                   res_valid,
	input  logic                   res_ready,
	input  logic [TID_FIELD_W-1:0] res_tid,
	input  logic [CODE_W-1:0]      res_code,
	input  logic                   res_last,
	output int unsigned            mismatches,
	output int unsigned            outstanding
);

	// Shadow copy of the lock and its two wait lines.
	logic writer_held;
	tid_t owner_tid;
	rc_t  read_holds;
	tid_t writer_waitq[$];
	tid_t reader_waitq[$];
	res_t expected_results[$];
	int unsigned fail_count;

	assign mismatches = fail_count;

	function automatic res_t make_result(input res_code_t code, input tid_t tid,
			input logic last);
		res_t r;
		r.code = code;
		r.tid = tid;
		r.last = last;
		return r;
	endfunction

	// Appends one predicted result beat behind the ones already owed.
	function automatic void add_expected(input res_code_t code, input tid_t tid,
			input logic last);
		expected_results.insert(expected_results.size(), make_result(code, tid, last));
	endfunction

	// A release first drops the hold, then hands the lock on: a waiting writer
	// wins over any number of waiting readers.
	task automatic predict_unlock(input tid_t tid);
		tid_t woken;
		if (writer_held) begin
			if (owner_tid != tid) begin
				add_expected(RES_NOT_OWNER, tid, 1'b1);
				return;
			end
			writer_held = 1'b0;
			owner_tid = '0;
		end else if (read_holds != '0) begin
			read_holds = read_holds - rc_t'(1);
		end else begin
			add_expected(RES_NOT_OWNER, tid, 1'b1);
			return;
		end
		if (read_holds != '0) begin
			add_expected(RES_GRANTED, tid, 1'b1);
			return;
		end
		if (writer_waitq.size() != 0) begin
			woken = writer_waitq[0];
			writer_waitq.delete(0);
			writer_held = 1'b1;
			owner_tid = woken;
			add_expected(RES_GRANTED, tid, 1'b0);
			add_expected(RES_WAKE_WRITE, woken, 1'b1);
			return;
		end
		add_expected(RES_GRANTED, tid, reader_waitq.size() == 0);
		while (reader_waitq.size() != 0) begin
			woken = reader_waitq[0];
			reader_waitq.delete(0);
			read_holds = read_holds + rc_t'(1);
			add_expected(RES_WAKE_READ, woken, reader_waitq.size() == 0);
		end
	endtask

	task automatic predict_request(input logic [KIND_W-1:0] kind, input tid_t tid);
		case (kind)
			KIND_READ: begin
				if (!writer_held && writer_waitq.size() == 0) begin
					if (read_holds == RC_MAX) begin
						add_expected(RES_FULL, tid, 1'b1);
					end else begin
						read_holds = read_holds + rc_t'(1);
						add_expected(RES_GRANTED, tid, 1'b1);
					end
				end else if (reader_waitq.size() < QUEUE_DEPTH) begin
					reader_waitq.insert(reader_waitq.size(), tid);
					add_expected(RES_QUEUED, tid, 1'b1);
				end else begin
					add_expected(RES_FULL, tid, 1'b1);
				end
			end
			KIND_WRITE: begin
				if (!writer_held && read_holds == '0) begin
					writer_held = 1'b1;
					owner_tid = tid;
					add_expected(RES_GRANTED, tid, 1'b1);
				end else if (writer_waitq.size() < QUEUE_DEPTH) begin
					writer_waitq.insert(writer_waitq.size(), tid);
					add_expected(RES_QUEUED, tid, 1'b1);
				end else begin
					add_expected(RES_FULL, tid, 1'b1);
				end
			end
			KIND_UNLOCK: predict_unlock(tid);
			default: ;
		endcase
	endtask

	task automatic check_result();
		res_t want;
		if (expected_results.size() == 0) begin
			$error("unexpected result beat: result_code %0d thread_id 0x%02h last %0b",
				res_code, res_tid, res_last);
			fail_count++;
			return;
		end
		want = expected_results[0];
		expected_results.delete(0);
		if (res_code !== want.code) begin
			$error("result_code: expected %0d, actual %0d", want.code, res_code);
			fail_count++;
		end
		if (res_tid !== TID_FIELD_W'(want.tid)) begin
			$error("thread_id: expected 0x%02h, actual 0x%02h", want.tid, res_tid);
			fail_count++;
		end
		if (res_last !== want.last) begin
			$error("last: expected %0b, actual %0b", want.last, res_last);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			writer_held = 1'b0;
			owner_tid = '0;
			read_holds = '0;
			writer_waitq.delete();
			reader_waitq.delete();
			expected_results.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (req_valid && req_ready) begin
				predict_request(req_kind, tid_t'(req_tid));
			end
			if (res_valid && res_ready) begin
				check_result();
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// File: dv/writer_preferring_rwlock_tb.sv
`timescale 1ns / 100ps

module writer_preferring_rwlock_tb;
	import rwl_pkg::*;

	// The run is stopped here no matter what; a correct run needs a small
	// fraction of this even with every result waiting out a receiver stall.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Quiet cycles after the last expected result, so that a stray extra beat
	// from the block still gets caught.
	localparam int DRAIN_CYCLES = 40;
	// Length of the deliberate receiver hold-off.
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int RANDOM_ITEMS = 309;
	// The one request kind the block has no meaning for; it must be dropped.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TID_FIELD_W-1:0] s_axis_tdata;
	logic [KIND_W-1:0]      s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TID_FIELD_W-1:0] m_axis_tdata;
	logic [CODE_W-1:0]      m_axis_tuser;
	logic                   m_axis_tlast;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count = 0;

	// Idle rates in percent for the request side and the result side.
	int unsigned send_idle_pct = 19;
	int unsigned recv_idle_pct = 58;
	// Bumped by the stimulus to ask the receiver for one long hold-off.
	int unsigned hold_off_reqs = 0;

	// Bookkeeping for the random part. It is not a model of the lock: it only
	// remembers which lock requests still owe an unlock, so that most unlocks
	// come from the thread that is likely to hold the lock.
	logic [TID_FIELD_W-1:0] owed_writers[$];
	int unsigned            owed_readers = 0;
	logic [TID_FIELD_W-1:0] recent_writers[8];
	int unsigned            recent_slot = 0;

	writer_preferring_rwlock u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	rwlock_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req_tid     (s_axis_tdata),
		.req_kind    (s_axis_tuser),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_tid     (m_axis_tdata),
		.res_code    (m_axis_tuser),
		.res_last    (m_axis_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// A hung block must not hang the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[writer_preferring_rwlock] ERROR");
			$finish;
		end
	end

	// Result side. Normally tready follows the current idle rate. When the
	// stimulus asks for a hold-off, tready stays low for a long stretch while
	// requests keep coming, so the output register backs up and the block
	// has to stall its request side.
	initial begin : receiver
		int unsigned served;
		served = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (served != hold_off_reqs) begin
				served = hold_off_reqs;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one request beat, after a random number of idle cycles, and
	// returns at the edge where it is taken. tvalid is left high, so that a
	// following beat can go out back to back.
	task automatic offer_request(input logic [KIND_W-1:0] kind,
			input logic [TID_FIELD_W-1:0] tid);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= tid;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stops offering and waits until every predicted result has come back.
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// One random request. Most are lock requests and the unlocks that pair with them
	// from a likely holder; the rest are stray unlocks, dropped kinds and
	// unlocks naming a recent writer, which also frees an owner that the
	// bookkeeping has lost track of.
	task automatic offer_random_request();
		int unsigned pick;
		logic [TID_FIELD_W-1:0] tid;
		logic [KIND_W-1:0] kind;
		pick = $urandom_range(99);
		tid = 8'($urandom_range(255));
		// Too many lock requests outstanding: push toward releases so the
		// queues keep moving instead of sitting full.
		if (owed_writers.size() + owed_readers > 24 && pick >= 10) begin
			pick = 99;
		end
		if (pick < 4) begin
			kind = KIND_UNUSED;
		end else if (pick < 8) begin
			kind = KIND_UNLOCK;
		end else if (pick < 12) begin
			kind = KIND_UNLOCK;
			tid = recent_writers[$urandom_range(7)];
		end else if (pick < 39) begin
			kind = KIND_READ;
			owed_readers++;
		end else if (pick < 58) begin
			kind = KIND_WRITE;
			owed_writers.insert(owed_writers.size(), tid);
			recent_writers[recent_slot] = tid;
			recent_slot = (recent_slot + 1) % 8;
		end else begin
			kind = KIND_UNLOCK;
			if (owed_writers.size() != 0 && (owed_readers == 0 || $urandom_range(1) == 1)) begin
				tid = owed_writers[0];
				owed_writers.delete(0);
			end else if (owed_readers != 0) begin
				owed_readers--;
			end
		end
		offer_request(kind, tid);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		for (int i = 0; i < 8; i++) recent_writers[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the lock: unlock of a free lock, readers
		// sharing, a writer waiting behind readers and blocking new readers,
		// a dropped kind, a waiter handed the lock, an owner queuing a second
		// write behind itself, unlock by a non-owner, a reader drain, and
		// the extreme thread identifiers. It ends with the lock free.
		offer_request(KIND_UNLOCK, 8'h00);
		offer_request(KIND_READ,   8'h00);
		offer_request(KIND_READ,   8'hFF);
		offer_request(KIND_WRITE,  8'hAA);
		offer_request(KIND_READ,   8'h55);
		offer_request(KIND_UNUSED, 8'h3C);
		offer_request(KIND_UNLOCK, 8'h01);
		offer_request(KIND_UNLOCK, 8'hFE);
		offer_request(KIND_READ,   8'h0F);
		offer_request(KIND_WRITE,  8'hAA);
		offer_request(KIND_UNLOCK, 8'h33);
		offer_request(KIND_UNLOCK, 8'hAA);
		offer_request(KIND_UNLOCK, 8'hAA);
		offer_request(KIND_WRITE,  8'h01);
		offer_request(KIND_UNLOCK, 8'h55);
		offer_request(KIND_UNLOCK, 8'h0F);
		offer_request(KIND_UNLOCK, 8'h01);
		offer_request(KIND_UNLOCK, 8'h01);
		offer_request(KIND_WRITE,  8'h7F);
		offer_request(KIND_READ,   8'h80);
		offer_request(KIND_UNLOCK, 8'h7F);
		offer_request(KIND_UNLOCK, 8'h80);
		offer_request(KIND_UNUSED, 8'hC3);
		wait_results_drained();

		// Both wait lines filled to the brim and one past it, with the
		// receiver held off so the block backs up. Then the writers are
		// released in line order; the last one wakes every waiting reader
		// at once, which is the longest result train the block can make.
		hold_off_reqs++;
		offer_request(KIND_WRITE, 8'h80);
		for (int i = 0; i <= QUEUE_DEPTH; i++) offer_request(KIND_WRITE, 8'(8'h90 + i));
		for (int i = 0; i <= QUEUE_DEPTH; i++) offer_request(KIND_READ, 8'(8'h40 + i));
		offer_request(KIND_UNLOCK, 8'h80);
		for (int i = 0; i < QUEUE_DEPTH; i++) offer_request(KIND_UNLOCK, 8'(8'h90 + i));
		for (int i = 0; i < QUEUE_DEPTH; i++) offer_request(KIND_UNLOCK, 8'(8'h40 + i));
		wait_results_drained();

		// Random traffic under three idle profiles: slow receiver, then slow
		// sender, then no idling at all. Pauses until everything is answered
		// are sprinkled in, and one more long receiver hold-off.
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
				if (p == 2 && i == 30) begin
					hold_off_reqs++;
				end
				if (i % 45 == 44) begin
					wait_results_drained();
				end
				offer_random_request();
			end
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[writer_preferring_rwlock] OK");
		end else begin
			$display("[writer_preferring_rwlock] ERROR");
		end
		$finish;
	end

endmodule
